// ----- hdl/cltw_pkg.sv -----
// Shared types, codes and constants of the character LCD text writer.
`default_nettype none

package cltw_pkg;

    localparam int COLUMNS_DEF = 20;
    localparam int LINES_DEF   = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;
    localparam int ADDR_W      = 7;

    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_RAW  = 2'd1;
    localparam logic [1:0] OP_SET  = 2'd2;
    localparam logic [1:0] OP_HOME = 2'd3;

    localparam logic [2:0] REG_LINE0  = 3'd0;
    localparam logic [2:0] REG_LINE1  = 3'd1;
    localparam logic [2:0] REG_LINE2  = 3'd2;
    localparam logic [2:0] REG_LINE3  = 3'd3;
    localparam logic [2:0] REG_ESCAPE = 3'd4;

    localparam logic [6:0] LINE0_RST = 7'd0;
    localparam logic [6:0] LINE1_RST = 7'd64;
    localparam logic [6:0] LINE2_RST = 7'd20;
    localparam logic [6:0] LINE3_RST = 7'd84;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_R     = 8'h72;
    localparam logic [7:0] CHAR_N     = 8'h6E;
    localparam logic [7:0] INSTR_HOME = 8'h02;
    localparam logic       SET_DDRAM  = 1'b1;

    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    typedef struct packed {
        logic [3:0][ADDR_W-1:0] line_base;
        logic                   escape_mode;
    } t_cfg;

    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       last;
    } t_qentry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] set_addr_byte(logic [ADDR_W-1:0] base,
                                                 logic [ADDR_W-1:0] col);
        logic [ADDR_W-1:0] addr;
        addr = base + col;
        return {SET_DDRAM, addr};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cltw_if.sv -----
// Valid/ready channel interfaces for command items and LCD nibble items.
`default_nettype none

interface cltw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [1:0] line_sel;
    logic [4:0] column;

    modport source (output valid, output opcode, output data_byte, output line_sel,
                    output column, input ready);
    modport sink   (input valid, input opcode, input data_byte, input line_sel,
                    input column, output ready);
endinterface

interface cltw_out_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;

    modport source (output valid, output reg_select, output nibble, output last,
                    input ready);
    modport sink   (input valid, input reg_select, input nibble, input last,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/cltw_front.sv -----
// Command front end: accepts items, tracks the cursor and emits byte writes.
`default_nettype none

module cltw_front #(
    parameter int COLUMNS = cltw_pkg::COLUMNS_DEF,
    parameter int LINES   = cltw_pkg::LINES_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    cltw_in_if.sink              i_cmd,
    input  cltw_pkg::t_cfg       i_cfg,
    input  cltw_pkg::t_q_status  i_q_stat,
    output logic                 o_push,
    output cltw_pkg::t_qentry    o_push_entry
);

    localparam int COL_W = $clog2(COLUMNS + 1);

    logic             r_hold;
    logic [1:0]       r_op;
    logic [7:0]       r_data;
    logic [1:0]       r_line_sel;
    logic [4:0]       r_col_in;
    logic             r_second;
    logic             r_wrapped;
    logic [1:0]       r_line;
    logic [COL_W-1:0] r_col;

    logic             n_second;
    logic             n_wrapped;
    logic [1:0]       n_line;
    logic [COL_W-1:0] n_col;

    logic             esc_seq;
    logic             at_break;
    logic             wrap_need;
    logic [2:0]       cur_line3;
    logic [2:0]       nl_line3;
    logic [1:0]       wrap_line;
    logic [1:0]       nl_line;
    logic [1:0]       sat_line;
    logic [COL_W-1:0] sat_col;
    logic [7:0]       cur_char;
    logic             push_need;
    logic             step_done;
    logic             advance;
    logic             finish;
    cltw_pkg::t_qentry entry;

    always_comb begin
        esc_seq   = (r_op == cltw_pkg::OP_CHAR) && i_cfg.escape_mode &&
                    ((r_data == cltw_pkg::CHAR_CR) || (r_data == cltw_pkg::CHAR_LF));
        at_break  = (r_col == COL_W'(COLUMNS));
        cur_line3 = {1'b0, r_line} + {2'b00, at_break};
        nl_line3  = cur_line3 + 3'd1;
        wrap_need = !r_wrapped && (at_break || ((r_col == '0) && (r_line != 2'd0)));
        wrap_line = (cur_line3 >= 3'(LINES)) ? 2'd0 : cur_line3[1:0];
        nl_line   = (nl_line3 >= 3'(LINES)) ? 2'd0 : nl_line3[1:0];
        sat_line  = ({1'b0, r_line_sel} >= 3'(LINES)) ? 2'(LINES - 1) : r_line_sel;
        sat_col   = ({1'b0, r_col_in} >= 6'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                       : COL_W'(r_col_in);
        if (esc_seq && r_second) begin
            cur_char = (r_data == cltw_pkg::CHAR_CR) ? cltw_pkg::CHAR_R : cltw_pkg::CHAR_N;
        end else if (esc_seq) begin
            cur_char = cltw_pkg::CHAR_SLASH;
        end else begin
            cur_char = r_data;
        end

        push_need  = 1'b0;
        step_done  = 1'b0;
        entry      = '0;
        n_second   = r_second;
        n_wrapped  = r_wrapped;
        n_line     = r_line;
        n_col      = r_col;

        case (r_op)
            cltw_pkg::OP_CHAR: begin
                if (!esc_seq && (r_data == cltw_pkg::CHAR_CR)) begin
                    step_done = 1'b1;
                end else if (!esc_seq && (r_data == cltw_pkg::CHAR_LF)) begin
                    push_need  = 1'b1;
                    entry.rs   = cltw_pkg::RS_INSTR;
                    entry.data = cltw_pkg::set_addr_byte(i_cfg.line_base[nl_line], '0);
                    entry.last = 1'b1;
                    n_line     = nl_line;
                    n_col      = '0;
                    step_done  = 1'b1;
                end else if (wrap_need) begin
                    push_need  = 1'b1;
                    entry.rs   = cltw_pkg::RS_INSTR;
                    entry.data = cltw_pkg::set_addr_byte(i_cfg.line_base[wrap_line], '0);
                    n_line     = wrap_line;
                    n_col      = '0;
                    n_wrapped  = 1'b1;
                end else begin
                    push_need  = 1'b1;
                    entry.rs   = cltw_pkg::RS_DATA;
                    entry.data = cur_char;
                    n_col      = r_col + COL_W'(1);
                    n_wrapped  = 1'b0;
                    if (esc_seq && !r_second) begin
                        n_second = 1'b1;
                    end else begin
                        entry.last = 1'b1;
                        step_done  = 1'b1;
                    end
                end
            end
            cltw_pkg::OP_RAW: begin
                push_need  = 1'b1;
                entry.rs   = cltw_pkg::RS_INSTR;
                entry.data = r_data;
                entry.last = 1'b1;
                step_done  = 1'b1;
            end
            cltw_pkg::OP_SET: begin
                push_need  = 1'b1;
                entry.rs   = cltw_pkg::RS_INSTR;
                entry.data = cltw_pkg::set_addr_byte(i_cfg.line_base[sat_line],
                                                     7'(sat_col));
                entry.last = 1'b1;
                n_line     = sat_line;
                n_col      = sat_col;
                step_done  = 1'b1;
            end
            default: begin
                push_need  = 1'b1;
                entry.rs   = cltw_pkg::RS_INSTR;
                entry.data = cltw_pkg::INSTR_HOME;
                entry.last = 1'b1;
                n_line     = 2'd0;
                n_col      = '0;
                step_done  = 1'b1;
            end
        endcase

        advance = r_hold && (!push_need || !i_q_stat.full);
        finish  = advance && step_done;
    end

    assign o_push       = r_hold && push_need && !i_q_stat.full;
    assign o_push_entry = entry;
    assign i_cmd.ready  = !r_hold || finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold    <= 1'b0;
            r_second  <= 1'b0;
            r_wrapped <= 1'b0;
            r_line    <= 2'd0;
            r_col     <= '0;
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                r_hold <= 1'b1;
            end else if (finish) begin
                r_hold <= 1'b0;
            end
            if (advance) begin
                r_line    <= n_line;
                r_col     <= n_col;
                r_second  <= finish ? 1'b0 : n_second;
                r_wrapped <= finish ? 1'b0 : n_wrapped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_op       <= i_cmd.opcode;
            r_data     <= i_cmd.data_byte;
            r_line_sel <= i_cmd.line_sel;
            r_col_in   <= i_cmd.column;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cltw_queue.sv -----
// Short byte-write queue between the command front end and the bus back end.
`default_nettype none

module cltw_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  cltw_pkg::t_qentry    i_push_entry,
    input  wire                  i_pop,
    output cltw_pkg::t_qentry    o_head,
    output cltw_pkg::t_q_status  o_stat
);

    localparam int DEPTH = cltw_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cltw_pkg::t_qentry r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_cnt;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cltw_back.sv -----
// Bus back end: splits byte writes into high and low nibbles on the output.
`default_nettype none

module cltw_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  cltw_pkg::t_qentry    i_head,
    input  cltw_pkg::t_q_status  i_q_stat,
    output logic                 o_pop,
    cltw_out_if.source           o_lcd
);

    logic       r_out_valid;
    logic       r_out_rs;
    logic [3:0] r_out_nib;
    logic       r_out_last;
    logic       r_have_lo;
    logic       r_lo_rs;
    logic [3:0] r_lo_nib;
    logic       r_lo_last;
    logic       load;

    assign load  = !r_out_valid || o_lcd.ready;
    assign o_pop = load && !r_have_lo && !i_q_stat.empty;

    assign o_lcd.valid      = r_out_valid;
    assign o_lcd.reg_select = r_out_rs;
    assign o_lcd.nibble     = r_out_nib;
    assign o_lcd.last       = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_have_lo   <= 1'b0;
        end else if (load) begin
            if (r_have_lo) begin
                r_out_valid <= 1'b1;
                r_have_lo   <= 1'b0;
            end else begin
                r_out_valid <= !i_q_stat.empty;
                r_have_lo   <= !i_q_stat.empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_have_lo) begin
                r_out_rs   <= r_lo_rs;
                r_out_nib  <= r_lo_nib;
                r_out_last <= r_lo_last;
            end else if (!i_q_stat.empty) begin
                r_out_rs   <= i_head.rs;
                r_out_nib  <= i_head.data[7:4];
                r_out_last <= 1'b0;
                r_lo_rs    <= i_head.rs;
                r_lo_nib   <= i_head.data[3:0];
                r_lo_last  <= i_head.last;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/char_lcd_text_writer.sv -----
// Top level of the character LCD text writer: config registers and the datapath.
//
// Each command item becomes a series of 4-bit bus writes, high nibble first, with
// a software cursor kept for a COLUMNS x LINES display. Characters wrap to the
// next line's start; a newline moves to column 0 of the next line; a carriage
// return makes no write unless escape mode prints it as "/r". A raw instruction,
// set-cursor, home or plain character makes one byte write, a character at a line
// break two, an escaped CR or LF up to four. One nibble leaves per cycle while
// o_lcd.ready is high and writes are queued; the output port sets the rate. The
// front end pushes a byte write per cycle while the queue is not full and takes a
// new item as the last finishes; item, queue and output registers precede the bus.
`default_nettype none

module char_lcd_text_writer #(
    parameter int COLUMNS = cltw_pkg::COLUMNS_DEF,
    parameter int LINES   = cltw_pkg::LINES_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    cltw_in_if.sink                      i_cmd,
    cltw_out_if.source                   o_lcd,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [cltw_pkg::PADDR_W-1:0]  paddr,
    input  wire [cltw_pkg::PDATA_W-1:0]  pwdata,
    output logic [cltw_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    cltw_pkg::t_cfg      r_cfg;
    cltw_pkg::t_q_status q_stat;
    cltw_pkg::t_qentry   q_push_entry;
    cltw_pkg::t_qentry   q_head;
    logic                q_push;
    logic                q_pop;
    logic [2:0]          reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_base[0] <= cltw_pkg::LINE0_RST;
            r_cfg.line_base[1] <= cltw_pkg::LINE1_RST;
            r_cfg.line_base[2] <= cltw_pkg::LINE2_RST;
            r_cfg.line_base[3] <= cltw_pkg::LINE3_RST;
            r_cfg.escape_mode  <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                cltw_pkg::REG_LINE0:  r_cfg.line_base[0] <= pwdata[6:0];
                cltw_pkg::REG_LINE1:  r_cfg.line_base[1] <= pwdata[6:0];
                cltw_pkg::REG_LINE2:  r_cfg.line_base[2] <= pwdata[6:0];
                cltw_pkg::REG_LINE3:  r_cfg.line_base[3] <= pwdata[6:0];
                cltw_pkg::REG_ESCAPE: r_cfg.escape_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            cltw_pkg::REG_LINE0:  prdata = 32'(r_cfg.line_base[0]);
            cltw_pkg::REG_LINE1:  prdata = 32'(r_cfg.line_base[1]);
            cltw_pkg::REG_LINE2:  prdata = 32'(r_cfg.line_base[2]);
            cltw_pkg::REG_LINE3:  prdata = 32'(r_cfg.line_base[3]);
            cltw_pkg::REG_ESCAPE: prdata = 32'(r_cfg.escape_mode);
            default:              prdata = '0;
        endcase
    end

    cltw_front #(
        .COLUMNS (COLUMNS),
        .LINES   (LINES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_cfg        (r_cfg),
        .i_q_stat     (q_stat),
        .o_push       (q_push),
        .o_push_entry (q_push_entry)
    );

    cltw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_entry (q_push_entry),
        .i_pop        (q_pop),
        .o_head       (q_head),
        .o_stat       (q_stat)
    );

    cltw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_lcd    (o_lcd)
    );

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("byte write pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("byte write popped from an empty queue");

    a_stall_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_stat.full && !q_pop) |=> !q_push || q_pop)
        else $error("queue overrun after a stall");

endmodule

`default_nettype wire
